@@ hw/rtl/http_connect_reply_parser_top_assert.svh @@
// assertion macros for the connect reply parser
`ifndef HTTP_CONNECT_REPLY_PARSER_TOP_ASSERT_SVH
`define HTTP_CONNECT_REPLY_PARSER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define HCRP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcrp assertion failed");
`define HCRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcrp assertion failed");
`else
`define HCRP_ASSERT_SAME(label, clk, rst, ante, cons)
`define HCRP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/hcrp_pkg.sv @@
package hcrp_pkg;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HEADER = 2'd1,
      PH_TUNNEL = 2'd2
   } phase_type;

   localparam logic [1:0] OP_LINK_UP  = 2'd0;
   localparam logic [1:0] OP_BYTE     = 2'd1;
   localparam logic [1:0] OP_CLOSED   = 2'd2;
   localparam logic [1:0] OP_LINK_ERR = 2'd3;

   localparam logic [1:0] LEK_HOST    = 2'd0;
   localparam logic [1:0] LEK_REFUSED = 2'd1;
   localparam logic [1:0] LEK_READ    = 2'd2;

   localparam logic [1:0] KIND_OPENED  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;
   localparam logic [1:0] KIND_CLOSED  = 2'd3;

   localparam logic [2:0] EC_AUTH    = 3'd0;
   localparam logic [2:0] EC_HOST    = 3'd1;
   localparam logic [2:0] EC_NEG     = 3'd2;
   localparam logic [2:0] EC_REFUSED = 3'd3;
   localparam logic [2:0] EC_PROXY   = 3'd4;
   localparam logic [2:0] EC_READ    = 3'd5;

   localparam logic [9:0] CODE_OK      = 10'd200;
   localparam logic [9:0] CODE_AUTH    = 10'd407;
   localparam logic [9:0] CODE_HOST    = 10'd404;
   localparam logic [9:0] CODE_FORBID  = 10'd403;
   localparam logic [9:0] CODE_UNAVAIL = 10'd503;
   localparam logic [9:0] CODE_MAX     = 10'd999;

   localparam logic [7:0] CHAR_CR   = 8'h0d;
   localparam logic [7:0] CHAR_LF   = 8'h0a;
   localparam logic [7:0] CHAR_SP   = 8'h20;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
      logic [1:0] link_error_kind;
   } req_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload;
      logic [2:0] error_class;
      logic [9:0] status_code;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } step_result_type;

   typedef struct packed {
      logic       pending_cr;
      logic       on_first_line;
      logic       line_is_empty;
      logic [1:0] field_index;
      logic [9:0] code_value;
      logic       code_bad;
      logic       first_line_done;
   } parse_type;

   localparam parse_type PARSE_CLEAR = '{
      pending_cr:      1'b0,
      on_first_line:   1'b1,
      line_is_empty:   1'b1,
      field_index:     2'd0,
      code_value:      10'd0,
      code_bad:        1'b0,
      first_line_done: 1'b0
   };

   function automatic parse_type content_byte(parse_type s, logic [7:0] b);
      parse_type   r;
      logic [13:0] v;
      r = s;
      v = 14'(s.code_value) * 14'd10 + 14'(b[3:0]);
      r.line_is_empty = 1'b0;
      if (s.on_first_line) begin
         if (b == CHAR_SP) begin
            if (s.field_index != 2'd2) begin
               r.field_index = s.field_index + 2'd1;
            end
         end else if (s.field_index == 2'd1) begin
            if (b inside {[CHAR_ZERO:CHAR_NINE]}) begin
               r.code_value = (v > 14'(CODE_MAX)) ? CODE_MAX : v[9:0];
            end else begin
               r.code_bad = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [2:0] error_class_of(logic [9:0] code);
      logic [2:0] ec;
      case (code)
         CODE_AUTH:    ec = EC_AUTH;
         CODE_HOST:    ec = EC_HOST;
         CODE_FORBID:  ec = EC_NEG;
         CODE_UNAVAIL: ec = EC_REFUSED;
         default:      ec = EC_NEG;
      endcase
      return ec;
   endfunction

endpackage

@@ hw/rtl/hcrp_req_if.sv @@
interface hcrp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] rx_byte;
   logic [1:0] link_error_kind;

   modport source (output valid, output op, output rx_byte, output link_error_kind,
                   input ready);
   modport sink (input valid, input op, input rx_byte, input link_error_kind,
                 output ready);
endinterface

@@ hw/rtl/hcrp_rsp_if.sv @@
interface hcrp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] payload;
   logic [2:0] error_class;
   logic [9:0] status_code;

   modport source (output valid, output kind, output payload, output error_class,
                   output status_code, input ready);
   modport sink (input valid, input kind, input payload, input error_class,
                 input status_code, output ready);
endinterface

@@ hw/rtl/hcrp_in_stage.sv @@
module hcrp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   hcrp_req_if.sink              req,
   input  logic                  advance,
   output logic                  item_valid,
   output hcrp_pkg::req_item_type item
);

   logic                   valid_ff;
   logic                   valid_in;
   hcrp_pkg::req_item_type item_ff;
   logic                   take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{op: req.op, rx_byte: req.rx_byte,
                      link_error_kind: req.link_error_kind};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ hw/rtl/hcrp_parser.sv @@
module hcrp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  hcrp_pkg::req_item_type   item,
   output hcrp_pkg::step_result_type result
);

   hcrp_pkg::phase_type phase_ff;
   hcrp_pkg::phase_type phase_in;
   hcrp_pkg::parse_type ps_ff;
   hcrp_pkg::parse_type ps_in;
   hcrp_pkg::step_result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hcrp_pkg::PH_IDLE;
         ps_ff    <= hcrp_pkg::PARSE_CLEAR;
      end else if (fire) begin
         phase_ff <= phase_in;
         ps_ff    <= ps_in;
      end
   end

   always_comb begin
      hcrp_pkg::parse_type t;
      logic [9:0]          code;
      phase_in = phase_ff;
      ps_in    = ps_ff;
      res      = '0;
      t        = ps_ff;
      code     = 10'd0;
      case (item.op)
         hcrp_pkg::OP_LINK_UP: begin
            ps_in    = hcrp_pkg::PARSE_CLEAR;
            phase_in = hcrp_pkg::PH_HEADER;
         end
         hcrp_pkg::OP_BYTE: begin
            case (phase_ff)
               hcrp_pkg::PH_TUNNEL: begin
                  res.valid        = 1'b1;
                  res.item.kind    = hcrp_pkg::KIND_PAYLOAD;
                  res.item.payload = item.rx_byte;
               end
               hcrp_pkg::PH_HEADER: begin
                  t.pending_cr = 1'b0;
                  if (ps_ff.pending_cr && item.rx_byte == hcrp_pkg::CHAR_LF) begin
                     // line end
                     if (!t.line_is_empty) begin
                        if (t.on_first_line) begin
                           t.on_first_line   = 1'b0;
                           t.first_line_done = 1'b1;
                        end
                        t.line_is_empty = 1'b1;
                     end else begin
                        phase_in      = hcrp_pkg::PH_IDLE;
                        res.valid     = 1'b1;
                        res.item.kind = hcrp_pkg::KIND_ERROR;
                        if (!t.first_line_done || t.field_index != 2'd2) begin
                           res.item.error_class = hcrp_pkg::EC_NEG;
                        end else begin
                           code = t.code_bad ? 10'd0 : t.code_value;
                           res.item.status_code = code;
                           if (code == hcrp_pkg::CODE_OK) begin
                              phase_in      = hcrp_pkg::PH_TUNNEL;
                              res.item.kind = hcrp_pkg::KIND_OPENED;
                           end else begin
                              res.item.error_class = hcrp_pkg::error_class_of(code);
                           end
                        end
                     end
                  end else begin
                     // lone cr counts as content
                     if (ps_ff.pending_cr) begin
                        t.line_is_empty = 1'b0;
                        if (t.on_first_line && t.field_index == 2'd1) begin
                           t.code_bad = 1'b1;
                        end
                     end
                     if (item.rx_byte == hcrp_pkg::CHAR_CR) begin
                        t.pending_cr = 1'b1;
                     end else begin
                        t = hcrp_pkg::content_byte(t, item.rx_byte);
                     end
                  end
                  ps_in = t;
               end
               default: begin
               end
            endcase
         end
         hcrp_pkg::OP_CLOSED: begin
            phase_in  = hcrp_pkg::PH_IDLE;
            res.valid = 1'b1;
            if (phase_ff == hcrp_pkg::PH_TUNNEL) begin
               res.item.kind = hcrp_pkg::KIND_CLOSED;
            end else begin
               res.item.kind        = hcrp_pkg::KIND_ERROR;
               res.item.error_class = hcrp_pkg::EC_NEG;
            end
         end
         default: begin
            phase_in      = hcrp_pkg::PH_IDLE;
            res.item.kind = hcrp_pkg::KIND_ERROR;
            if (phase_ff == hcrp_pkg::PH_TUNNEL) begin
               res.valid            = 1'b1;
               res.item.error_class = hcrp_pkg::EC_READ;
            end else begin
               case (item.link_error_kind)
                  hcrp_pkg::LEK_HOST, hcrp_pkg::LEK_REFUSED: begin
                     res.valid            = 1'b1;
                     res.item.error_class = hcrp_pkg::EC_PROXY;
                  end
                  hcrp_pkg::LEK_READ: begin
                     res.valid            = 1'b1;
                     res.item.error_class = hcrp_pkg::EC_NEG;
                  end
                  default: begin
                  end
               endcase
            end
         end
      endcase
   end

   assign result = res;

endmodule

@@ hw/rtl/hcrp_out_stage.sv @@
module hcrp_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  hcrp_pkg::rsp_item_type item,
   output logic                   slot_free,
   hcrp_rsp_if.source             rsp
);

   logic                   valid_ff;
   logic                   valid_in;
   hcrp_pkg::rsp_item_type item_ff;

   assign slot_free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = item_ff.kind;
   assign rsp.payload     = item_ff.payload;
   assign rsp.error_class = item_ff.error_class;
   assign rsp.status_code = item_ff.status_code;

endmodule

@@ hw/rtl/http_connect_reply_parser_top.sv @@
// channel  ports  direction  item
// req      req.*  in         op, rx_byte, link_error_kind
// rsp      rsp.*  out        kind, payload, error_class, status_code
//
// one item per cycle unless rsp stalls; results pass the input, then the output register
// the parse state updates as an item leaves the input register, one step per item
// synchronous reset clears both stage valids, the phase and the parse state
// an item with no result leaves even while rsp is stalled
// an item with a result waits in the input register until the output register frees
`include "http_connect_reply_parser_top_assert.svh"

module http_connect_reply_parser_top (
   input  logic        clock,
   input  logic        reset,
   hcrp_req_if.sink    req,
   hcrp_rsp_if.source  rsp
);

   logic                      item_valid;
   hcrp_pkg::req_item_type    item;
   hcrp_pkg::step_result_type result;
   logic                      slot_free;
   logic                      advance;
   logic                      rsp_payload;
   logic                      rsp_opened;
   logic                      payload_zero;

   assign advance = item_valid && (slot_free || !result.valid);

   hcrp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   hcrp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   hcrp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && result.valid),
      .item      (result.item),
      .slot_free (slot_free),
      .rsp       (rsp)
   );

   assign rsp_payload  = rsp.valid && rsp.kind == hcrp_pkg::KIND_PAYLOAD;
   assign rsp_opened   = rsp.valid && rsp.kind == hcrp_pkg::KIND_OPENED;
   assign payload_zero = rsp.error_class == hcrp_pkg::EC_AUTH && rsp.status_code == 10'd0;

   `HCRP_ASSERT_SAME(a_payload_clean, clock, reset, rsp_payload, payload_zero)
   `HCRP_ASSERT_SAME(a_opened_code, clock, reset, rsp_opened, rsp.status_code == hcrp_pkg::CODE_OK)
   `HCRP_ASSERT_SAME(a_code_range, clock, reset, rsp.valid, rsp.status_code <= hcrp_pkg::CODE_MAX)
   `HCRP_ASSERT_NEXT(a_item_held, clock, reset, item_valid && !advance, item_valid)

endmodule
